FILE: design/dsss_pkg.sv
package dsss_pkg;

  // Sizing
  localparam int MAX_SAMPLES   = 64;
  localparam int PN_LENGTH     = 15;
  localparam int SAMPLE_WIDTH  = 16;
  localparam int CARRIER_STEPS = 8;
  localparam int CARRIER_W     = 16;
  localparam int CFG_W         = 7;
  localparam int ERR_W         = 24;

  localparam int POS_W   = $clog2(MAX_SAMPLES);
  localparam int LEN_W   = $clog2(MAX_SAMPLES + 1);
  localparam int CHIP_W  = $clog2(PN_LENGTH);
  localparam int STEP_W  = $clog2(CARRIER_STEPS);
  localparam int PROD_W  = SAMPLE_WIDTH + CARRIER_W;
  // |product| <= 2^(SAMPLE_WIDTH+13), summed over up to 2^POS_W samples
  localparam int SUM_W   = SAMPLE_WIDTH + CARRIER_W - 1 + POS_W;
  localparam int CMP_W   = (CFG_W > LEN_W) ? CFG_W : LEN_W;

  // Register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLES_PER_SYMBOL = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHIP_PERIOD        = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPREAD_ENABLE      = 2'd2;

  localparam logic [CFG_W-1:0] SPSYM_RESET = CFG_W'(60);
  localparam logic [CFG_W-1:0] CPER_RESET  = CFG_W'(4);

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  // Chips that are -1 in the 15-chip PN code, bit i for chip i
  localparam logic [PN_LENGTH-1:0] PN_NEG = 15'b110_0101_0000_1110;

  typedef struct packed {
    logic [LEN_W-1:0] spsym;
    logic [LEN_W-1:0] cper;
    logic             spread_en;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

  // Force a length register into 1..MAX_SAMPLES
  function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] raw);
    logic [CMP_W-1:0] v;
    logic [LEN_W-1:0] r;
    v = CMP_W'(raw);
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > CMP_W'(MAX_SAMPLES)) begin
      r = LEN_W'(MAX_SAMPLES);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

  // cos(2*pi*n/8) in Q1.14
  function automatic logic signed [CARRIER_W-1:0] carrier_q14(input logic [STEP_W-1:0] n);
    logic signed [CARRIER_W-1:0] c;
    unique case (n)
      3'd0:    c = 16'sd16384;
      3'd1:    c = 16'sd11585;
      3'd2:    c = 16'sd0;
      3'd3:    c = -16'sd11585;
      3'd4:    c = -16'sd16384;
      3'd5:    c = -16'sd11585;
      3'd6:    c = 16'sd0;
      default: c = 16'sd11585;
    endcase
    return c;
  endfunction

endpackage

FILE: design/dsss_in_if.sv
interface dsss_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [dsss_pkg::SAMPLE_WIDTH-1:0] sample;
  logic                                     ref_bit;

  modport source (output valid, output sample, output ref_bit, input ready);
  modport sink   (input valid, input sample, input ref_bit, output ready);
endinterface

FILE: design/dsss_out_if.sv
interface dsss_out_if;
  logic                            valid;
  logic                            ready;
  logic                            detected_bit;
  logic                            bit_error;
  logic [dsss_pkg::ERR_W-1:0]      error_tally;

  modport source (output valid, output detected_bit, output bit_error, output error_tally,
                  input ready);
  modport sink   (input valid, input detected_bit, input bit_error, input error_tally,
                  output ready);
endinterface

FILE: design/dsss_cfg_if.sv
interface dsss_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [dsss_pkg::REG_IDX_W-1:0]     index;
  logic [dsss_pkg::CFG_W-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/dsss_cfg_regs.sv
module dsss_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_valid,
  output logic                              wr_ready,
  input  logic [dsss_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [dsss_pkg::CFG_W-1:0]        wr_data,
  output dsss_pkg::cfg_t                    cfg
);

  dsss_pkg::cfg_t regs;

  assign wr_ready = 1'b1;
  assign cfg      = regs;

  // Store lengths already clamped; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.spsym     <= dsss_pkg::clamp_len(dsss_pkg::SPSYM_RESET);
      regs.cper      <= dsss_pkg::clamp_len(dsss_pkg::CPER_RESET);
      regs.spread_en <= 1'b1;
    end else if (wr_valid) begin
      unique case (wr_index)
        dsss_pkg::REG_SAMPLES_PER_SYMBOL: regs.spsym     <= dsss_pkg::clamp_len(wr_data);
        dsss_pkg::REG_CHIP_PERIOD:        regs.cper      <= dsss_pkg::clamp_len(wr_data);
        dsss_pkg::REG_SPREAD_ENABLE:      regs.spread_en <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/dsss_mixer.sv
module dsss_mixer (
  input  logic                                     clk,
  input  logic                                     rst,
  input  dsss_pkg::cfg_t                           cfg,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [dsss_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic                                     in_ref,
  output dsss_pkg::stage_ctrl_t                    pb_ctrl,
  output logic signed [dsss_pkg::PROD_W-1:0]       pb_prod,
  output logic                                     pb_ref,
  input  logic                                     pb_free
);

  logic                                     ia_valid;
  logic signed [dsss_pkg::SAMPLE_WIDTH-1:0] ia_sample;
  logic                                     ia_ref;

  logic [dsss_pkg::POS_W-1:0]  sample_position;
  logic [dsss_pkg::POS_W-1:0]  chip_sample_count;
  logic [dsss_pkg::CHIP_W-1:0] chip_index;

  logic                                  ia_move;
  logic                                  sym_end;
  logic                                  chip_end;
  logic signed [dsss_pkg::CARRIER_W-1:0] carrier;
  logic signed [dsss_pkg::CARRIER_W-1:0] carrier_sel;
  logic signed [dsss_pkg::PROD_W-1:0]    prod;

  assign ia_move  = ia_valid && pb_free;
  assign in_ready = !ia_valid || pb_free;

  // End of symbol and end of chip against the current lengths
  assign sym_end  = ({1'b0, sample_position} + 1'b1) >= dsss_pkg::LEN_W'(cfg.spsym);
  assign chip_end = ({1'b0, chip_sample_count} + 1'b1) >= dsss_pkg::LEN_W'(cfg.cper);

  // Flip the carrier for a negative chip, then one multiply
  assign carrier     = dsss_pkg::carrier_q14(sample_position[dsss_pkg::STEP_W-1:0]);
  assign carrier_sel = (cfg.spread_en && dsss_pkg::PN_NEG[chip_index]) ? -carrier : carrier;
  assign prod        = dsss_pkg::PROD_W'(ia_sample) * dsss_pkg::PROD_W'(carrier_sel);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ia_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ia_valid <= 1'b1;
    end else if (ia_move) begin
      ia_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ia_sample <= in_sample;
      ia_ref    <= in_ref;
    end
  end

  // Advance symbol and chip counters once per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position   <= '0;
      chip_sample_count <= '0;
      chip_index        <= '0;
    end else if (ia_move) begin
      if (sym_end) begin
        sample_position   <= '0;
        chip_sample_count <= '0;
        chip_index        <= '0;
      end else begin
        sample_position <= sample_position + 1'b1;
        if (chip_end) begin
          chip_sample_count <= '0;
          chip_index        <= (chip_index == dsss_pkg::CHIP_W'(dsss_pkg::PN_LENGTH - 1))
                               ? '0 : chip_index + 1'b1;
        end else begin
          chip_sample_count <= chip_sample_count + 1'b1;
        end
      end
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (rst) begin
      pb_ctrl.valid <= 1'b0;
    end else if (ia_move) begin
      pb_ctrl.valid <= 1'b1;
    end else if (pb_free) begin
      pb_ctrl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ia_move) begin
      pb_ctrl.last <= sym_end;
      pb_prod      <= prod;
      pb_ref       <= ia_ref;
    end
  end

endmodule

FILE: design/dsss_accum.sv
module dsss_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  dsss_pkg::stage_ctrl_t              pb_ctrl,
  input  logic signed [dsss_pkg::PROD_W-1:0] pb_prod,
  input  logic                               pb_ref,
  output logic                               pb_free,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_detected,
  output logic                               out_error,
  output logic [dsss_pkg::ERR_W-1:0]         out_count
);

  logic signed [dsss_pkg::SUM_W-1:0] correlation_sum;
  logic [dsss_pkg::ERR_W-1:0]        error_total;

  logic signed [dsss_pkg::SUM_W-1:0] sum_new;
  logic                              out_free;
  logic                              pb_move;
  logic                              det;
  logic                              err;
  logic [dsss_pkg::ERR_W-1:0]        error_total_next;

  assign out_free = !out_valid || out_ready;
  // Mid-symbol beats never wait on the result register
  assign pb_move  = pb_ctrl.valid && (!pb_ctrl.last || out_free);
  assign pb_free  = !pb_ctrl.valid || pb_move;

  // Accumulate and decide; a zero sum decides 0
  assign sum_new = correlation_sum + dsss_pkg::SUM_W'(pb_prod);
  assign det     = !sum_new[dsss_pkg::SUM_W-1] && (sum_new != '0);
  assign err     = det != pb_ref;
  assign error_total_next = (err && error_total != dsss_pkg::ERR_MAX)
                            ? error_total + 1'b1 : error_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      correlation_sum <= '0;
      error_total     <= '0;
    end else if (pb_move) begin
      if (pb_ctrl.last) begin
        correlation_sum <= '0;
        error_total     <= error_total_next;
      end else begin
        correlation_sum <= sum_new;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pb_move && pb_ctrl.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pb_move && pb_ctrl.last) begin
      out_detected <= det;
      out_error    <= err;
      out_count    <= error_total_next;
    end
  end

endmodule

FILE: design/dsss_bpsk_despread_detector.sv
// DS-BPSK correlation receiver. One signed Q2.13 sample is taken per beat and may
// arrive every clock cycle while the input is not stalled; it is mixed with an eight-step
// cosine carrier and, when spread_enable is set, with a 15-chip PN code whose chip lasts
// a programmable number of samples and restarts with each symbol. After samples_per_symbol
// samples one result beat carries the decided bit (1 when the sum is positive), whether
// it differs from ref_bit of that last sample, and the saturating error total. A sample
// passes an input register, one multiply into a product register, and one accumulate
// and decide into the result register. A waiting result stalls the input only when the
// next symbol end reaches it. Lengths of 0 act as 1 and lengths above 64 act as 64;
// configuration writes are always ready and never clear the symbol state.
module dsss_bpsk_despread_detector (
  input  logic        clk,
  input  logic        rst,
  dsss_cfg_if.sink    cfg,
  dsss_in_if.sink     samples,
  dsss_out_if.source  results
);

  dsss_pkg::cfg_t                           cfg_q;
  dsss_pkg::stage_ctrl_t                    pb_ctrl;
  logic signed [dsss_pkg::PROD_W-1:0]       pb_prod;
  logic                                     pb_ref;
  logic                                     pb_free;

  dsss_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  dsss_mixer u_mixer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_sample (samples.sample),
    .in_ref    (samples.ref_bit),
    .pb_ctrl   (pb_ctrl),
    .pb_prod   (pb_prod),
    .pb_ref    (pb_ref),
    .pb_free   (pb_free)
  );

  dsss_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .pb_ctrl      (pb_ctrl),
    .pb_prod      (pb_prod),
    .pb_ref       (pb_ref),
    .pb_free      (pb_free),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_detected (results.detected_bit),
    .out_error    (results.bit_error),
    .out_count    (results.error_tally)
  );

endmodule

FILE: design/dsss_checker.sv
module dsss_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_error,
  input logic [dsss_pkg::ERR_W-1:0] out_count
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A reported error implies a nonzero total
  a_err_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_count != '0)
    else $error("bit error with zero error total");

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Configuration writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind dsss_bpsk_despread_detector dsss_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_error (results.bit_error),
  .out_count (results.error_tally)
);

FILE: tb/dsss_decision_checker.sv
module dsss_decision_checker (
  input  logic clk,
  input  logic rst,
  dsss_cfg_if  cfg,
  dsss_in_if   samples,
  dsss_out_if  results,
  output int   failures,
  output int   outstanding,
  output int   symbols_checked,
  output int   errors_flagged
);
  import dsss_pkg::*;

  // cos(2*pi*n/8) scaled by 2^14
  localparam int COS_Q14 [CARRIER_STEPS] = '{16384, 11585, 0, -11585, -16384, -11585, 0, 11585};
  // Chips of the spreading code that invert the product
  localparam logic [PN_LENGTH-1:0] PN_INVERT = 15'b110_0101_0000_1110;

  typedef struct packed {
    logic             detected_bit;
    logic             bit_error;
    logic [ERR_W-1:0] error_tally;
  } decision_t;

  // Shadow registers and symbol state
  logic [CFG_W-1:0]  spsym_reg;
  logic [CFG_W-1:0]  cper_reg;
  logic              spread_reg;
  logic [5:0]        sym_pos;
  logic [5:0]        chip_cnt;
  logic [3:0]        chip_idx;
  logic signed [36:0] corr_acc;
  logic [ERR_W-1:0]  err_total;

  decision_t decision_q[$];
  int        fail_count;
  int        sym_count;
  int        err_seen;

  // Lengths of zero act as one, anything past the maximum acts as the maximum
  function automatic int eff_len(input logic [CFG_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v == 0) begin
      v = 1;
    end else if (v > MAX_SAMPLES) begin
      v = MAX_SAMPLES;
    end
    return v;
  endfunction

  // Mix one sample into the running correlation; queue a decision at symbol end
  task automatic correlate_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic rb);
    int                 n_sym;
    int                 n_chip;
    logic signed [31:0] prod;
    decision_t          d;
    n_sym  = eff_len(spsym_reg);
    n_chip = eff_len(cper_reg);
    prod   = s * COS_Q14[sym_pos[2:0]];
    if (spread_reg && PN_INVERT[chip_idx]) begin
      prod = -prod;
    end
    corr_acc = corr_acc + prod;

    // Advance the chip counters even when spreading is off
    if (int'(chip_cnt) + 1 >= n_chip) begin
      chip_cnt = '0;
      chip_idx = (chip_idx == 4'(PN_LENGTH - 1)) ? 4'd0 : chip_idx + 4'd1;
    end else begin
      chip_cnt = chip_cnt + 6'd1;
    end

    if (int'(sym_pos) + 1 < n_sym) begin
      sym_pos = sym_pos + 6'd1;
    end else begin
      d.detected_bit = (corr_acc > 0);
      d.bit_error    = (d.detected_bit != rb);
      if (d.bit_error && err_total != ERR_MAX) begin
        err_total = err_total + 1'b1;
      end
      d.error_tally = err_total;
      decision_q.push_back(d);
      sym_pos  = '0;
      chip_cnt = '0;
      chip_idx = '0;
      corr_acc = '0;
    end
  endtask

  always @(posedge clk) begin
    decision_t want;
    if (rst) begin
      spsym_reg  = SPSYM_RESET;
      cper_reg   = CPER_RESET;
      spread_reg = 1'b1;
      sym_pos    = '0;
      chip_cnt   = '0;
      chip_idx   = '0;
      corr_acc   = '0;
      err_total  = '0;
      decision_q.delete();
      fail_count = 0;
      sym_count  = 0;
      err_seen   = 0;
    end else begin
      // Compare a result beat with the oldest decision
      if (results.valid && results.ready) begin
        if (decision_q.size() == 0) begin
          $error("result beat with no decision pending");
          fail_count++;
        end else begin
          want = decision_q.pop_front();
          sym_count++;
          if (results.bit_error) begin
            err_seen++;
          end
          if (results.detected_bit !== want.detected_bit) begin
            $error("detected_bit: expected %0d, actual %0d", want.detected_bit,
                   results.detected_bit);
            fail_count++;
          end
          if (results.bit_error !== want.bit_error) begin
            $error("bit_error: expected %0d, actual %0d", want.bit_error, results.bit_error);
            fail_count++;
          end
          if (results.error_tally !== want.error_tally) begin
            $error("error_tally: expected %0d, actual %0d", want.error_tally,
                   results.error_tally);
            fail_count++;
          end
        end
      end

      // Track register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SAMPLES_PER_SYMBOL: spsym_reg  = cfg.data;
          REG_CHIP_PERIOD:        cper_reg   = cfg.data;
          REG_SPREAD_ENABLE:      spread_reg = cfg.data[0];
          default: ;
        endcase
      end

      // Predict from each accepted sample beat
      if (samples.valid && samples.ready) begin
        correlate_sample(samples.sample, samples.ref_bit);
      end
    end
    failures        <= fail_count;
    outstanding     <= decision_q.size();
    symbols_checked <= sym_count;
    errors_flagged  <= err_seen;
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import dsss_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 165;
  localparam int PRESSURE_ITEMS = 150;
  localparam int END_WAIT_LIMIT = 5000;
  localparam int RUN_LIMIT      = 400000;
  localparam int RANDOM_SETTING = -1;
  localparam int NUM_PHASES     = 12;

  // Settings swept by the random part, in order
  localparam int SPSYM_PLAN [NUM_PHASES] = '{60, 8, 64, 2, 127, 16, 15, 0,
                                             RANDOM_SETTING, RANDOM_SETTING, RANDOM_SETTING, 1};
  localparam int CPER_PLAN  [NUM_PHASES] = '{4, 1, 64, 3, 65, 2, 1, 0,
                                             RANDOM_SETTING, RANDOM_SETTING, RANDOM_SETTING, 1};
  localparam int SPREAD_PLAN[NUM_PHASES] = '{1, 1, 1, 0, 1, 0, 1, 1,
                                             RANDOM_SETTING, RANDOM_SETTING, RANDOM_SETTING, 1};

  logic clk;
  logic rst;

  dsss_cfg_if cfg_ch ();
  dsss_in_if  smp_ch ();
  dsss_out_if res_ch ();

  int failures;
  int outstanding;
  int symbols_checked;
  int errors_flagged;
  int hold_requests;
  int holds_done;
  int items_sent;
  int settings_run;

  dsss_bpsk_despread_detector dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (smp_ch),
    .results (res_ch)
  );

  dsss_decision_checker decision_chk (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg_ch),
    .samples         (smp_ch),
    .results         (res_ch),
    .failures        (failures),
    .outstanding     (outstanding),
    .symbols_checked (symbols_checked),
    .errors_flagged  (errors_flagged)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop
  initial begin
    #(2 * RUN_LIMIT);
    $display("dsss_bpsk_despread_detector regression: fail");
    $finish;
  end

  // Write one register; valid stays high for a following write
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_config(input int spsym, input int cper, input int spread);
    write_reg(REG_SAMPLES_PER_SYMBOL, CFG_W'(spsym));
    write_reg(REG_CHIP_PERIOD, CFG_W'(cper));
    write_reg(REG_SPREAD_ENABLE, CFG_W'(spread));
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  // Offer one sample beat and hold it until taken; valid is left high
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic rb);
    smp_ch.valid   <= 1'b1;
    smp_ch.sample  <= s;
    smp_ch.ref_bit <= rb;
    do @(posedge clk); while (!smp_ch.ready);
    items_sent++;
  endtask

  task automatic pause_input(input int n);
    smp_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid, wait for every pending decision, then let the pipeline empty
  task automatic settle();
    pause_input(1);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    logic signed [SAMPLE_WIDTH-1:0] s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       s = 16'sh7FFF;
          1:       s = 16'sh8000;
          2:       s = '0;
          3:       s = 16'sh0001;
          default: s = '1;
        endcase
      end
      1, 2: s = SAMPLE_WIDTH'(int'($urandom_range(0, 8)) - 4);
      default: s = SAMPLE_WIDTH'($urandom);
    endcase
    return s;
  endfunction

  // Random samples in bursts, with or without gaps between them
  task automatic run_random(input int count, input bit with_gaps);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 48);
      repeat (burst) begin
        if (left > 0) begin
          send_sample(rand_sample(), 1'($urandom_range(0, 1)));
          left--;
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (with_gaps && gap > 0 && left > 0) begin
        pause_input(gap);
      end
    end
  endtask

  // Result sink: stall patterns that change now and then, plus requested long holds
  initial begin
    int mode;
    int left_in_mode;
    mode         = 0;
    left_in_mode = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_done++;
      end else begin
        if (left_in_mode == 0) begin
          mode         = $urandom_range(0, 3);
          left_in_mode = $urandom_range(20, 200);
        end
        left_in_mode--;
        case (mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       res_ch.ready <= ($urandom_range(0, 7) != 0);
          default: res_ch.ready <= ((left_in_mode % 5) < 2);
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int p;
    int spsym;
    int cper;
    int spread;
    int waited;
    hold_requests = 0;
    holds_done    = 0;
    items_sent    = 0;
    settings_run  = 0;
    rst            <= 1'b1;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    smp_ch.valid   <= 1'b0;
    smp_ch.sample  <= '0;
    smp_ch.ref_bit <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One-sample symbols, plain BPSK: extremes, zero sum, both reference bits
    set_config(1, 1, 0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh0001, 1'b1);
    send_sample(16'shFFFF, 1'b0);
    settle();

    // Three-sample symbols, spread, chip period zero acting as one
    set_config(3, 0, 1);
    send_sample(16'sh4000, 1'b1);
    send_sample(16'sh4000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'shC000, 1'b0);
    send_sample(16'sh2000, 1'b1);
    send_sample(16'sh8000, 1'b1);
    settle();

    // Symbol length zero acts as one, chip period past the maximum
    set_config(0, 127, 1);
    send_sample(16'sh1234, 1'b0);
    send_sample(16'shEDCC, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    settle();

    // Sweep the settings; state carries across so symbols straddle changes
    for (p = 0; p < NUM_PHASES; p++) begin
      spsym  = (SPSYM_PLAN[p] == RANDOM_SETTING) ? $urandom_range(0, 127) : SPSYM_PLAN[p];
      cper   = (CPER_PLAN[p] == RANDOM_SETTING) ? $urandom_range(0, 127) : CPER_PLAN[p];
      spread = (SPREAD_PLAN[p] == RANDOM_SETTING) ? $urandom_range(0, 1) : SPREAD_PLAN[p];
      if (spsym == 0) begin
        write_reg(REG_UNUSED, CFG_W'($urandom));
      end
      set_config(spsym, cper, spread);
      if (p == NUM_PHASES - 1) begin
        // Hold the sink off while samples keep coming so the input backs up
        hold_requests++;
        run_random(PRESSURE_ITEMS, 1'b0);
      end else begin
        run_random(PHASE_ITEMS, 1'b1);
      end
      settle();
    end

    // Final drain with a bound
    pause_input(1);
    waited = 0;
    while (outstanding != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (outstanding != 0) begin
      $error("%0d decisions never arrived", outstanding);
    end

    $display("Sent %0d samples over %0d register settings, including clamped lengths",
             items_sent, settings_run);
    $display("Checked %0d symbol decisions, %0d of them flagged as bit errors",
             symbols_checked, errors_flagged);
    if (failures == 0 && outstanding == 0) begin
      $display("dsss_bpsk_despread_detector regression: pass");
    end else begin
      $display("dsss_bpsk_despread_detector regression: fail");
    end
    $finish;
  end

endmodule

FILE: dsss_bpsk_despread_detector.f
design/dsss_pkg.sv
design/dsss_in_if.sv
design/dsss_out_if.sv
design/dsss_cfg_if.sv
design/dsss_cfg_regs.sv
design/dsss_mixer.sv
design/dsss_accum.sv
design/dsss_bpsk_despread_detector.sv
design/dsss_checker.sv
tb/dsss_decision_checker.sv
tb/tb_top.sv
